>>> hdl/csolv_pkg.sv
// Package with the item types and constants of the 3x3 Cramer solver.
package csolv_pkg;

   localparam int COEF_WIDTH = 16;
   localparam int RESULT_FRAC_BITS = 16;
   localparam int SOL_WIDTH = 32;
   localparam int QUOT_BITS = SOL_WIDTH + 1;

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] a_x1;
      logic signed [COEF_WIDTH-1:0] a_x2;
      logic signed [COEF_WIDTH-1:0] a_x3;
      logic signed [COEF_WIDTH-1:0] a_y1;
      logic signed [COEF_WIDTH-1:0] a_y2;
      logic signed [COEF_WIDTH-1:0] a_y3;
      logic signed [COEF_WIDTH-1:0] a_z1;
      logic signed [COEF_WIDTH-1:0] a_z2;
      logic signed [COEF_WIDTH-1:0] a_z3;
      logic signed [COEF_WIDTH-1:0] rhs_1;
      logic signed [COEF_WIDTH-1:0] rhs_2;
      logic signed [COEF_WIDTH-1:0] rhs_3;
   } req_type;

   typedef struct packed {
      logic signed [SOL_WIDTH-1:0] sol_x;
      logic signed [SOL_WIDTH-1:0] sol_y;
      logic signed [SOL_WIDTH-1:0] sol_z;
      logic                        singular;
      logic                        overflow;
   } rsp_type;

endpackage

>>> hdl/cramer_3x3_solver.sv
// Top level of the pipelined 3x3 linear system solver using Cramer's rule.
// Throughput: one item per cycle; busy stays low and nothing stalls.
// The quotient is formed by 33 restoring division stages, one bit each.
// Reset clears all valid bits synchronously; data registers are not reset.
// Results cannot be held off by the receiver.
module cramer_3x3_solver #(
   parameter int RESULT_FRAC_BITS = csolv_pkg::RESULT_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  csolv_pkg::req_type req_item,
   output logic               rsp_valid,
   output csolv_pkg::rsp_type rsp_item
);

   localparam int W = csolv_pkg::COEF_WIDTH;
   localparam int MW = 2 * W + 1;
   localparam int PW = 3 * W + 1;
   localparam int DET_W = 3 * W + 3;
   localparam int NUM_W = DET_W + RESULT_FRAC_BITS;
   localparam int QB = csolv_pkg::QUOT_BITS;
   localparam int SW = csolv_pkg::SOL_WIDTH;
   localparam int XW = (NUM_W > DET_W + QB) ? NUM_W : DET_W + QB;
   localparam int LATENCY = 6 + QB + 1;

   // Minor pairs (column a, column b): yz, xz, xy, rz, yr, xr.
   localparam int PA [6] = '{1, 0, 0, 3, 1, 0};
   localparam int PB [6] = '{2, 2, 1, 2, 3, 3};
   // Terms of D, DX, DY, DZ: top coefficient column, minor, subtract.
   localparam int TC [4][3] = '{'{0, 1, 2}, '{3, 1, 2}, '{0, 3, 2}, '{0, 1, 3}};
   localparam int TM [4][3] = '{'{0, 1, 2}, '{0, 3, 4}, '{3, 1, 5}, '{4, 5, 2}};
   localparam bit TS [4][3] = '{'{0, 1, 0}, '{0, 1, 1}, '{0, 1, 0}, '{0, 1, 0}};

   typedef struct packed {
      logic [2:0][XW-1:0] rem;
      logic [2:0][QB-1:0] quo;
      logic [DET_W-1:0]   den;
      logic [2:0]         neg;
      logic [2:0]         big;
      logic               sing;
   } dv_type;

   logic signed [W-1:0]     col [4][3];
   logic signed [2*W-1:0]   s1_pl_ff [6];
   logic signed [2*W-1:0]   s1_pr_ff [6];
   logic signed [W-1:0]     s1_top_ff [4];
   logic signed [MW-1:0]    s2_min_ff [6];
   logic signed [W-1:0]     s2_top_ff [4];
   logic signed [PW-1:0]    s3_prod_ff [4][3];
   logic signed [DET_W-1:0] s4_det_ff [4];
   logic signed [DET_W-1:0] s4_det_in [4];
   logic [DET_W-1:0]        s5_abs_ff [4];
   logic [2:0]              s5_neg_ff;
   logic                    s5_sing_ff;
   dv_type                  dv_ff [QB+1];
   dv_type                  dv0_in;
   logic [4:0]              pv_ff;
   logic [QB:0]             dvv_ff;
   csolv_pkg::rsp_type      rsp_in;
   csolv_pkg::rsp_type      rsp_ff;
   logic                    rsp_valid_ff;

   assign busy = 1'b0;

   always_comb begin
      col[0][0] = req_item.a_x1; col[0][1] = req_item.a_x2; col[0][2] = req_item.a_x3;
      col[1][0] = req_item.a_y1; col[1][1] = req_item.a_y2; col[1][2] = req_item.a_y3;
      col[2][0] = req_item.a_z1; col[2][1] = req_item.a_z2; col[2][2] = req_item.a_z3;
      col[3][0] = req_item.rhs_1; col[3][1] = req_item.rhs_2; col[3][2] = req_item.rhs_3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
         dvv_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pv_ff <= {pv_ff[3:0], start & ~busy};
         dvv_ff <= {dvv_ff[QB-1:0], pv_ff[4]};
         rsp_valid_ff <= dvv_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 6; k++) begin
         s1_pl_ff[k] <= col[PA[k]][1] * col[PB[k]][2];
         s1_pr_ff[k] <= col[PA[k]][2] * col[PB[k]][1];
         s2_min_ff[k] <= MW'(s1_pl_ff[k]) - MW'(s1_pr_ff[k]);
      end
      for (int c = 0; c < 4; c++) begin
         s1_top_ff[c] <= col[c][0];
         s2_top_ff[c] <= s1_top_ff[c];
      end
      for (int d = 0; d < 4; d++) begin
         for (int t = 0; t < 3; t++) begin
            s3_prod_ff[d][t] <= s2_top_ff[TC[d][t]] * s2_min_ff[TM[d][t]];
         end
      end
   end

   always_comb begin
      for (int d = 0; d < 4; d++) begin
         s4_det_in[d] = '0;
         for (int t = 0; t < 3; t++) begin
            if (TS[d][t]) begin
               s4_det_in[d] = s4_det_in[d] - DET_W'(s3_prod_ff[d][t]);
            end else begin
               s4_det_in[d] = s4_det_in[d] + DET_W'(s3_prod_ff[d][t]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      s4_det_ff <= s4_det_in;
      for (int d = 0; d < 4; d++) begin
         s5_abs_ff[d] <= s4_det_ff[d][DET_W-1] ? DET_W'(-s4_det_ff[d])
                                               : DET_W'(s4_det_ff[d]);
      end
      for (int j = 0; j < 3; j++) begin
         s5_neg_ff[j] <= s4_det_ff[j+1][DET_W-1] ^ s4_det_ff[0][DET_W-1];
      end
      s5_sing_ff <= (s4_det_ff[0] == '0);
   end

   always_comb begin
      dv0_in.den = s5_abs_ff[0];
      dv0_in.neg = s5_neg_ff;
      dv0_in.sing = s5_sing_ff;
      for (int j = 0; j < 3; j++) begin
         dv0_in.rem[j] = XW'(s5_abs_ff[j+1]) << RESULT_FRAC_BITS;
         dv0_in.quo[j] = '0;
         dv0_in.big[j] = (dv0_in.rem[j] >= (XW'(s5_abs_ff[0]) << QB));
      end
   end

   always_ff @(posedge clock) begin
      dv_ff[0] <= dv0_in;
   end

   for (genvar k = 0; k < QB; k++) begin : g_div
      localparam int BIT = QB - 1 - k;
      dv_type dv_in;
      always_comb begin
         dv_in = dv_ff[k];
         for (int j = 0; j < 3; j++) begin
            if (dv_ff[k].rem[j] >= (XW'(dv_ff[k].den) << BIT)) begin
               dv_in.rem[j] = dv_ff[k].rem[j] - (XW'(dv_ff[k].den) << BIT);
               dv_in.quo[j][BIT] = 1'b1;
            end
         end
      end
      always_ff @(posedge clock) begin
         dv_ff[k+1] <= dv_in;
      end
   end

   always_comb begin
      logic [2:0]        sat;
      logic [2:0][SW-1:0] val;
      for (int j = 0; j < 3; j++) begin
         if (dv_ff[QB].neg[j]) begin
            sat[j] = dv_ff[QB].big[j] || (dv_ff[QB].quo[j] > {1'b0, 1'b1, {(SW-1){1'b0}}});
            val[j] = sat[j] ? {1'b1, {(SW-1){1'b0}}} : SW'(-dv_ff[QB].quo[j]);
         end else begin
            sat[j] = dv_ff[QB].big[j] || (dv_ff[QB].quo[j] > {2'b00, {(SW-1){1'b1}}});
            val[j] = sat[j] ? {1'b0, {(SW-1){1'b1}}} : dv_ff[QB].quo[j][SW-1:0];
         end
      end
      if (dv_ff[QB].sing) begin
         rsp_in = '0;
         rsp_in.singular = 1'b1;
      end else begin
         rsp_in.sol_x = val[0];
         rsp_in.sol_y = val[1];
         rsp_in.sol_z = val[2];
         rsp_in.singular = 1'b0;
         rsp_in.overflow = |sat;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LATENCY rsp_valid)
      else $error("Result strobe missing after pipeline latency.");
   a_singular: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.singular |-> rsp_item.sol_x == '0 && rsp_item.sol_y == '0
         && rsp_item.sol_z == '0 && !rsp_item.overflow)
      else $error("Singular result carries nonzero fields.");
   a_divider: assert property (@(posedge clock) disable iff (reset)
      dvv_ff[0] |-> ##QB dvv_ff[QB])
      else $error("Item lost in divider stages.");
`endif

endmodule
